@@ hw/rtl/jhs_pkg.sv @@
package jhs_pkg;

    // Gamma table: 2^GAMMA_BITS intervals over the Q16 speed range.
    localparam int GAMMA_BITS  = 8;
    localparam int GAMMA_DEPTH = 1 << GAMMA_BITS;
    localparam int Q16_ONE     = 65536;

    // One quotient bit per cell; the Q16 speed needs 17 bits to reach 1.0.
    localparam int DIV_STEPS = 17;

    // Angle datapath: axis counts scaled by 2^20, angles in 2^-16 degree.
    localparam int ATAN_ENTRIES = 24;
    localparam int CW           = 34;
    localparam int ZW           = 28;
    localparam int AXIS_SHIFT   = 20;

    localparam logic signed [ZW-1:0] HALF_TURN = 28'sd11796480;
    localparam logic signed [ZW-1:0] FULL_TURN = 28'sd23592960;
    localparam int HEADING_LIMIT = 5760;

    // Percent scale and exact reciprocal of 100 for products below 2^15.
    localparam int PCT_SCALE   = 100;
    localparam int RECIP_100   = 20972;
    localparam int RECIP_SHIFT = 21;

    localparam logic signed [ZW-1:0] ATAN_STEP [ATAN_ENTRIES] = '{
        28'sd2949120, 28'sd1740967, 28'sd919879, 28'sd466945,
        28'sd234379,  28'sd117304,  28'sd58666,  28'sd29335,
        28'sd14668,   28'sd7334,    28'sd3667,   28'sd1833,
        28'sd917,     28'sd458,     28'sd229,    28'sd115,
        28'sd57,      28'sd29,      28'sd14,     28'sd7,
        28'sd4,       28'sd2,       28'sd1,      28'sd0
    };

    typedef enum logic [2:0] {
        REG_CENTER = 3'd0,
        REG_HALF   = 3'd1,
        REG_DEAD   = 3'd2,
        REG_SLOW   = 3'd3,
        REG_FAST   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [9:0] raw_x;
        logic [9:0] raw_y;
    } in_item_t;

    typedef struct packed {
        logic        idle;
        logic [12:0] heading;
        logic [6:0]  speed_percent;
        logic [7:0]  servo_delay;
    } out_item_t;

    typedef struct packed {
        logic [9:0] center_count;
        logic [9:0] half_range;
        logic [9:0] deadzone_counts;
        logic [7:0] slow_delay;
        logic [7:0] fast_delay;
    } cfg_t;

    // Everything one sample carries down the cell row.
    typedef struct packed {
        logic                 idle;
        logic                 zero_vec;
        logic                 den_zero;
        logic [10:0]          rem;
        logic [9:0]           den;
        logic [16:0]          quo;
        logic signed [CW-1:0] ca;
        logic signed [CW-1:0] cb;
        logic signed [ZW-1:0] cz;
    } cell_t;

    typedef logic [16:0] gamma_tab_t [GAMMA_DEPTH+1];

    // Entry i is the largest y <= 1.0 (Q16) with y^5 * D^8 <= 2^80 * i^8,
    // that is floor(65536 * (i / D)^1.6), found by binary search.
    function automatic gamma_tab_t build_gamma();
        gamma_tab_t   tab;
        logic [191:0] lhs;
        logic [191:0] rhs;
        logic [16:0]  lo;
        logic [16:0]  hi;
        logic [16:0]  mid;
        for (int i = 0; i <= GAMMA_DEPTH; i++) begin
            rhs = 192'(i);
            for (int p = 0; p < 7; p++) begin
                rhs = rhs * 192'(i);
            end
            rhs = rhs << 80;
            lo  = '0;
            hi  = 17'(Q16_ONE);
            for (int s = 0; s < 18; s++) begin
                if (lo < hi) begin
                    mid = 17'((32'(lo) + 32'(hi) + 32'd1) >> 1);
                    lhs = 192'(mid);
                    for (int p = 0; p < 4; p++) begin
                        lhs = lhs * 192'(mid);
                    end
                    lhs = lhs << (8 * GAMMA_BITS);
                    if (lhs <= rhs) begin
                        lo = mid;
                    end else begin
                        hi = mid - 17'd1;
                    end
                end
            end
            tab[i] = lo;
        end
        return tab;
    endfunction

    localparam gamma_tab_t GAMMA_TAB = build_gamma();

endpackage

@@ hw/rtl/jhs_stream_if.sv @@
interface jhs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/jhs_front.sv @@
module jhs_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  jhs_pkg::in_item_t item,
    input  jhs_pkg::cfg_t     cfg,
    output logic             out_valid,
    output jhs_pkg::cell_t    stage
);
    import jhs_pkg::*;

    // Center one axis and clamp it to the full-deflection range.
    function automatic logic signed [10:0] clamp_axis(
        input logic [9:0] raw,
        input logic [9:0] ctr,
        input logic [9:0] h
    );
        logic signed [10:0] d;
        logic signed [10:0] hs;
        d  = $signed({1'b0, raw}) - $signed({1'b0, ctr});
        hs = $signed({1'b0, h});
        if (d > hs) begin
            d = hs;
        end else if (d < -hs) begin
            d = -hs;
        end
        return d;
    endfunction

    logic [9:0]           half_eff;
    logic signed [10:0]   dx_next;
    logic signed [10:0]   dy_next;
    logic signed [10:0]   dx_reg;
    logic signed [10:0]   dy_reg;
    logic                 a_valid_reg;
    logic                 b_valid_reg;
    logic [9:0]           ax;
    logic [9:0]           ay;
    logic [9:0]           mag;
    logic signed [CW-1:0] xa;
    logic signed [CW-1:0] ya;
    cell_t                b_next;
    cell_t                b_reg;

    assign half_eff = (cfg.half_range == 10'd0) ? 10'd1 : cfg.half_range;
    assign dx_next  = clamp_axis(item.raw_x, cfg.center_count, half_eff);
    assign dy_next  = clamp_axis(item.raw_y, cfg.center_count, half_eff);

    always_comb
    begin
        ax  = 10'(dx_reg[10] ? -dx_reg : dx_reg);
        ay  = 10'(dy_reg[10] ? -dy_reg : dy_reg);
        mag = (ax > ay) ? ax : ay;
        xa  = {{(CW - 11 - AXIS_SHIFT){dx_reg[10]}}, dx_reg, {AXIS_SHIFT{1'b0}}};
        ya  = {{(CW - 11 - AXIS_SHIFT){dy_reg[10]}}, dy_reg, {AXIS_SHIFT{1'b0}}};

        b_next.idle     = mag < cfg.deadzone_counts;
        b_next.zero_vec = (dx_reg == 11'sd0) && (dy_reg == 11'sd0);
        b_next.den_zero = !(half_eff > cfg.deadzone_counts);
        b_next.den      = half_eff - cfg.deadzone_counts;
        b_next.rem      = {1'b0, mag - cfg.deadzone_counts};
        b_next.quo      = '0;

        // Vectors pointing backward are turned half a turn first.
        if (dy_reg[10]) begin
            b_next.ca = -ya;
            b_next.cb = -xa;
            b_next.cz = HALF_TURN;
        end else begin
            b_next.ca = ya;
            b_next.cb = xa;
            b_next.cz = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            b_reg  <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign stage     = b_reg;
endmodule

@@ hw/rtl/jhs_cell.sv @@
module jhs_cell #(
    parameter int STEP      = 0,
    parameter int ROT_STEPS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid_in,
    input  jhs_pkg::cell_t d_in,
    output logic           valid_out,
    output jhs_pkg::cell_t d_out
);
    import jhs_pkg::*;

    localparam bit DO_DIV   = STEP < DIV_STEPS;
    localparam bit DO_ROT   = STEP < ROT_STEPS;
    localparam int ATAN_IDX = STEP % ATAN_ENTRIES;

    logic                 valid_reg;
    cell_t                d_reg;
    cell_t                d_next;
    logic [10:0]          r_shift;
    logic                 r_ge;
    logic signed [CW-1:0] sa;
    logic signed [CW-1:0] sb;

    always_comb
    begin
        d_next  = d_in;
        // The first cell decides the integer bit, the rest shift first.
        r_shift = (STEP == 0) ? d_in.rem : {d_in.rem[9:0], 1'b0};
        r_ge    = r_shift >= {1'b0, d_in.den};
        sa      = $signed(d_in.ca) >>> STEP;
        sb      = $signed(d_in.cb) >>> STEP;

        if (DO_DIV) begin
            d_next.rem = r_ge ? (r_shift - {1'b0, d_in.den}) : r_shift;
            d_next.quo = {d_in.quo[15:0], r_ge};
        end

        // Vectoring step: drive the lateral component toward zero.
        if (DO_ROT) begin
            if (!d_in.cb[CW-1]) begin
                d_next.ca = d_in.ca + sb;
                d_next.cb = d_in.cb - sa;
                d_next.cz = d_in.cz + ATAN_STEP[ATAN_IDX];
            end else begin
                d_next.ca = d_in.ca - sb;
                d_next.cb = d_in.cb + sa;
                d_next.cz = d_in.cz - ATAN_STEP[ATAN_IDX];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign valid_out = valid_reg;
    assign d_out     = d_reg;
endmodule

@@ hw/rtl/jhs_post.sv @@
module jhs_post (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  jhs_pkg::cell_t      stage,
    input  jhs_pkg::cfg_t       cfg,
    output logic               out_valid,
    output jhs_pkg::out_item_t item
);
    import jhs_pkg::*;

    localparam int KW      = GAMMA_BITS + 1;
    localparam int FRAC_LO = 16 - GAMMA_BITS;

    logic [5:0] valid_reg;

    // Table lookup and heading wrap.
    logic [16:0]          s_q;
    logic [KW-1:0]        k_idx;
    logic [KW-1:0]        k_up;
    logic [15:0]          f_next;
    logic [16:0]          base_next;
    logic [16:0]          diff_next;
    logic signed [ZW-1:0] z_wrap;
    logic                 p1_idle_reg;
    logic                 p1_zero_reg;
    logic [16:0]          p1_base_reg;
    logic [16:0]          p1_diff_reg;
    logic [15:0]          p1_f_reg;
    logic [24:0]          p1_zw_reg;

    // Interpolation and heading rounding.
    logic [32:0] interp_prod;
    logic [16:0] g_next;
    logic [12:0] h_round;
    logic [12:0] h_next;
    logic        p2_idle_reg;
    logic [16:0] p2_g_reg;
    logic [12:0] p2_heading_reg;

    // Percent.
    logic [23:0] pct_prod;
    logic        p3_idle_reg;
    logic [6:0]  p3_pct_reg;
    logic [12:0] p3_heading_reg;

    // Delay span product.
    logic        up_next;
    logic [7:0]  span;
    logic        p4_idle_reg;
    logic [6:0]  p4_pct_reg;
    logic [12:0] p4_heading_reg;
    logic        p4_up_reg;
    logic [14:0] p4_scaled_reg;

    // Division by 100.
    logic [29:0] q_prod;
    logic        p5_idle_reg;
    logic [6:0]  p5_pct_reg;
    logic [12:0] p5_heading_reg;
    logic        p5_up_reg;
    logic [7:0]  p5_q_reg;

    logic [7:0]  delay_next;
    out_item_t   res_next;
    out_item_t   p6_item_reg;

    always_comb
    begin
        s_q = (stage.den_zero || (stage.quo > 17'(Q16_ONE))) ? 17'(Q16_ONE) : stage.quo;
        k_idx  = s_q[16:FRAC_LO];
        k_up   = (k_idx == KW'(GAMMA_DEPTH)) ? k_idx : (k_idx + 1'b1);
        f_next = {s_q[FRAC_LO-1:0], {GAMMA_BITS{1'b0}}};
        base_next = GAMMA_TAB[k_idx];
        diff_next = GAMMA_TAB[k_up] - GAMMA_TAB[k_idx];

        if (stage.cz < 0) begin
            z_wrap = stage.cz + FULL_TURN;
        end else if (stage.cz >= FULL_TURN) begin
            z_wrap = stage.cz - FULL_TURN;
        end else begin
            z_wrap = stage.cz;
        end

        interp_prod = 33'(p1_diff_reg) * 33'(p1_f_reg);
        g_next      = p1_base_reg + 17'(interp_prod >> 16);
        h_round     = 13'((p1_zw_reg + 25'd2048) >> 12);
        h_next      = ((h_round >= 13'(HEADING_LIMIT)) || p1_zero_reg) ? 13'd0 : h_round;

        pct_prod = 24'(p2_g_reg) * 24'(PCT_SCALE);

        up_next = cfg.fast_delay >= cfg.slow_delay;
        span    = up_next ? (cfg.fast_delay - cfg.slow_delay)
                          : (cfg.slow_delay - cfg.fast_delay);

        q_prod = 30'(p4_scaled_reg) * 30'(RECIP_100);

        delay_next = p5_up_reg ? (cfg.slow_delay + p5_q_reg) : (cfg.slow_delay - p5_q_reg);
        if (p5_idle_reg) begin
            res_next = '{idle: 1'b1, heading: '0, speed_percent: '0, servo_delay: '0};
        end else begin
            res_next = '{idle: 1'b0, heading: p5_heading_reg,
                         speed_percent: p5_pct_reg, servo_delay: delay_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            p1_idle_reg    <= stage.idle;
            p1_zero_reg    <= stage.zero_vec;
            p1_base_reg    <= base_next;
            p1_diff_reg    <= diff_next;
            p1_f_reg       <= f_next;
            p1_zw_reg      <= z_wrap[24:0];

            p2_idle_reg    <= p1_idle_reg;
            p2_g_reg       <= g_next;
            p2_heading_reg <= h_next;

            p3_idle_reg    <= p2_idle_reg;
            p3_pct_reg     <= 7'(pct_prod >> 16);
            p3_heading_reg <= p2_heading_reg;

            p4_idle_reg    <= p3_idle_reg;
            p4_pct_reg     <= p3_pct_reg;
            p4_heading_reg <= p3_heading_reg;
            p4_up_reg      <= up_next;
            p4_scaled_reg  <= 15'(p3_pct_reg) * 15'(span);

            p5_idle_reg    <= p4_idle_reg;
            p5_pct_reg     <= p4_pct_reg;
            p5_heading_reg <= p4_heading_reg;
            p5_up_reg      <= p4_up_reg;
            p5_q_reg       <= 8'(q_prod >> RECIP_SHIFT);

            p6_item_reg    <= res_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign item      = p6_item_reg;
endmodule

@@ hw/rtl/joystick_heading_speed_top.sv @@
// Channel   Role     Payload                                        Handshake
// sample    sink     raw_x, raw_y (10-bit converter samples)        valid / ready
// result    source   idle, heading, speed_percent, servo_delay      valid / ready
// apb       slave    five settings registers at byte offsets 0..16  psel / penable
//
// One request is taken per clock while sample.ready is high; a result passes the
// front registers, the cells, the post stages and the output register. The first
// DIV_STEPS cells resolve a quotient bit, the first ANGLE_STAGES an angle step.
// rst_n is asynchronous; it clears all valid bits and returns the settings
// registers to their reset values.
// A stalled result sits in the output register and one more in a skid register;
// sample.ready drops only while the skid register is full.
module joystick_heading_speed_top #(
    parameter int ANGLE_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    jhs_stream_if.sink         sample,
    jhs_stream_if.source       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import jhs_pkg::*;

    // The row is as long as the longer of the two jobs it carries.
    localparam int NCELL = (ANGLE_STAGES > DIV_STEPS) ? ANGLE_STAGES : DIV_STEPS;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      cfg_write;

    logic      en;
    cell_t     chain_d [NCELL+1];
    logic [NCELL:0] chain_v;
    logic      pipe_valid;
    out_item_t pipe_item;
    logic      arrive;
    logic      take;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_item_t skid_item_reg;
    out_item_t skid_item_next;

    // Settings port. Writes land on the access phase; pready never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_CENTER: cfg_next.center_count    = pwdata[9:0];
                REG_HALF:   cfg_next.half_range      = pwdata[9:0];
                REG_DEAD:   cfg_next.deadzone_counts = pwdata[9:0];
                REG_SLOW:   cfg_next.slow_delay      = pwdata[7:0];
                REG_FAST:   cfg_next.fast_delay      = pwdata[7:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_CENTER: prdata = 32'(cfg_reg.center_count);
            REG_HALF:   prdata = 32'(cfg_reg.half_range);
            REG_DEAD:   prdata = 32'(cfg_reg.deadzone_counts);
            REG_SLOW:   prdata = 32'(cfg_reg.slow_delay);
            REG_FAST:   prdata = 32'(cfg_reg.fast_delay);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.center_count    <= 10'd512;
            cfg_reg.half_range      <= 10'd512;
            cfg_reg.deadzone_counts <= 10'd77;
            cfg_reg.slow_delay      <= 8'd50;
            cfg_reg.fast_delay      <= 8'd10;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The whole row moves together. Since the skid register can absorb the one
    // result that leaves the row in the cycle a stall is first seen, the stall
    // is taken straight from a flop and ready carries no path from result.ready.
    assign en           = !skid_valid_reg;
    assign sample.ready = en;

    jhs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample.valid),
        .item      (sample.data),
        .cfg       (cfg_reg),
        .out_valid (chain_v[0]),
        .stage     (chain_d[0])
    );

    // A cell does a restoring-division step on the speed (below DIV_STEPS), a vectoring
    // step on the heading (below ANGLE_STAGES), and hands the sample to its neighbor.
    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        jhs_cell #(
            .STEP      (c),
            .ROT_STEPS (ANGLE_STAGES)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (chain_v[c]),
            .d_in      (chain_d[c]),
            .valid_out (chain_v[c+1]),
            .d_out     (chain_d[c+1])
        );
    end

    // Gamma shaping, percent, delay mapping and heading rounding.
    jhs_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_v[NCELL]),
        .stage     (chain_d[NCELL]),
        .cfg       (cfg_reg),
        .out_valid (pipe_valid),
        .item      (pipe_item)
    );

    assign arrive = pipe_valid && en;
    assign take   = out_valid_reg && result.ready;

    // Output register plus skid register. A result from the row goes to the
    // output register when it is free or being emptied, otherwise to the skid.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (skid_valid_reg) begin
            if (take) begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end else if (arrive) begin
            if (!out_valid_reg || take) begin
                out_valid_next = 1'b1;
                out_item_next  = pipe_item;
            end else begin
                skid_valid_next = 1'b1;
                skid_item_next  = pipe_item;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_item_reg;

    // The skid register is only ever filled behind a waiting output register.
    a_skid_behind_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg
    ) else $error("skid register holds a result while output register is empty");

    // A stalled skid result must not be dropped.
    a_skid_kept: assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !result.ready |=> skid_valid_reg
    ) else $error("skid result lost during stall");

    // Idle results carry no heading, speed or delay.
    a_idle_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid && result.data.idle |->
            result.data.heading == 13'd0 && result.data.speed_percent == 7'd0 &&
            result.data.servo_delay == 8'd0
    ) else $error("idle result with nonzero fields");

    // Heading stays below a full turn and speed at or below full scale.
    a_field_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |->
            result.data.heading < 13'(HEADING_LIMIT) &&
            result.data.speed_percent <= 7'(PCT_SCALE)
    ) else $error("result field out of range");
endmodule
